>>> hw/rtl/nlbm_pkg.sv
`default_nettype none

package nlbm_pkg;

    // defaults for the top level parameters
    localparam int MAX_SEGMENTS_DEF        = 16;
    localparam int LOGICAL_PER_SEGMENT_DEF = 1000;

    // fixed flash geometry
    localparam int PHYS_PER_SEGMENT  = 1024;
    localparam int SECTORS_PER_BLOCK = 256;

    // field and internal widths
    localparam int FLAT_W    = 14;
    localparam int SECTOR_W  = 22;
    localparam int SLOT_W    = 11;
    localparam int BLOCK_W   = 10;
    localparam int SEG_W     = 4;
    localparam int NSEG_W    = 5;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_KIND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT = 1'b1;

    // chip model codes
    localparam logic [1:0] MODEL_TWO_SEG  = 2'd1;
    localparam logic [1:0] MODEL_FOUR_SEG = 2'd2;

    // spare area constants
    localparam logic [SLOT_W-1:0] NO_SLOT     = 11'h7ff;
    localparam logic [15:0]       TAG_MASK    = 16'hf000;
    localparam logic [15:0]       TAG_VALUE   = 16'h1000;
    localparam logic [7:0]        GOOD_MARKER = 8'hff;

    typedef enum logic [1:0] {
        OP_START_SCAN  = 2'd0,
        OP_SCAN_RECORD = 2'd1,
        OP_LOOKUP      = 2'd2,
        OP_VERIFY      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED      = 3'd0,
        ST_CACHE_HIT     = 3'd1,
        ST_VERIFY_NEEDED = 3'd2,
        ST_FOUND         = 3'd3,
        ST_NOT_FOUND     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR    = 2'd0,
        S_IDLE     = 2'd1,
        S_MAP_READ = 2'd2,
        S_RESULT   = 2'd3
    } state_t;

    typedef struct packed {
        op_t          operation;
        logic [3:0]   segment;
        logic [9:0]   phys_block;
        logic [13:0]  logical_block;
        logic [7:0]   bad_marker;
        logic [15:0]  addr_copy_a;
        logic [15:0]  addr_copy_b;
    } req_t;

    typedef struct packed {
        status_t      status;
        logic [21:0]  phys_sector;
        logic [10:0]  decoded_logical;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic read_done;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic lookup_miss;
    } sts_t;

    // address field decode: equal tagged copies, or a single bit apart
    // with an even-parity tagged copy
    function automatic logic [SLOT_W-1:0] decode_slot(logic [15:0] a, logic [15:0] b);
        logic [15:0] diff;
        logic        tag_a;
        logic        tag_b;
        logic [SLOT_W-1:0] slot;
        diff  = a ^ b;
        tag_a = (a & TAG_MASK) == TAG_VALUE;
        tag_b = (b & TAG_MASK) == TAG_VALUE;
        if (a == b && tag_a)
            slot = a[11:1];
        else if ((diff & (diff - 16'd1)) != 16'd0)
            slot = NO_SLOT;
        else if (tag_a && !(^a))
            slot = a[11:1];
        else if (tag_b && !(^b))
            slot = b[11:1];
        else
            slot = NO_SLOT;
        return slot;
    endfunction

    // first sector of a flat physical block
    function automatic logic [SECTOR_W-1:0] sector_of(logic [FLAT_W-1:0] flat);
        logic [SECTOR_W:0] prod;
        prod = {{(SECTOR_W + 1 - FLAT_W){1'b0}}, flat} * (SECTOR_W + 1)'(SECTORS_PER_BLOCK);
        return prod[SECTOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nlbm_req_if.sv
`default_nettype none

interface nlbm_req_if;
    logic              valid;
    logic              ready;
    nlbm_pkg::req_t    data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/nlbm_rsp_if.sv
`default_nettype none

interface nlbm_rsp_if;
    logic              valid;
    logic              ready;
    nlbm_pkg::rsp_t    data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/nlbm_ram.sv
`default_nettype none

module nlbm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16000
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/nlbm_ctrl.sv
`default_nettype none

module nlbm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire nlbm_pkg::sts_t sts,
    output nlbm_pkg::cmd_t      cmd
);
    import nlbm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = sts.lookup_miss ? S_MAP_READ : S_RESULT;
            end
            S_MAP_READ:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.clear_en  = 1'b0;
        cmd.accept    = 1'b0;
        cmd.read_done = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_MAP_READ:
            begin
                cmd.read_done = 1'b1;
            end
            S_RESULT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/nlbm_dp.sv
`default_nettype none

module nlbm_dp #(
    parameter int MAX_SEGMENTS        = nlbm_pkg::MAX_SEGMENTS_DEF,
    parameter int LOGICAL_PER_SEGMENT = nlbm_pkg::LOGICAL_PER_SEGMENT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [nlbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [nlbm_pkg::CFG_W-1:0]       cfg_data,
    input  wire nlbm_pkg::req_t                   req_data,
    output nlbm_pkg::rsp_t                        rsp_data,
    input  wire nlbm_pkg::cmd_t                   cmd,
    output nlbm_pkg::sts_t                        sts
);
    import nlbm_pkg::*;

    localparam int MAP_DEPTH = MAX_SEGMENTS * LOGICAL_PER_SEGMENT;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int LIMIT_W   = FLAT_W + 1;

    // configuration
    logic [1:0]         model_kind_reg;
    logic [CFG_W-1:0]   chip_count_reg;

    // cache and pending lookup
    logic                 cached_valid_reg;
    logic [FLAT_W-1:0]    cached_block_reg;
    logic [SECTOR_W-1:0]  cached_start_reg;
    logic                 pending_valid_reg;
    logic [FLAT_W-1:0]    pending_logical_reg;
    logic [BLOCK_W-1:0]   pending_slot_reg;
    logic [SEG_W-1:0]     pending_seg_reg;
    logic [FLAT_W-1:0]    pending_phys_reg;

    // clearing pass and result
    logic [MAP_AW-1:0]    clear_cnt_reg;
    rsp_t                 rsp_reg;

    logic [2:0]           per_chip;
    logic [2:0]           chips;
    logic [NSEG_W-1:0]    seg_prod;
    logic [NSEG_W-1:0]    seg_count;
    logic [LIMIT_W-1:0]   lookup_limit;

    logic [SLOT_W-1:0]    slot;
    logic                 good;
    logic [FLAT_W-1:0]    scan_flat;
    logic [FLAT_W-1:0]    scan_addr;
    logic                 scan_ok;

    logic                 in_range;
    logic                 cache_hit;
    logic [SEG_W-1:0]     lookup_seg;
    logic [FLAT_W-1:0]    lookup_off;
    logic [BLOCK_W-1:0]   lookup_slot;
    logic                 lookup_miss;

    logic                 verify_ok;
    logic [SECTOR_W-1:0]  pending_sector;
    logic [FLAT_W-1:0]    map_phys;
    rsp_t                 result;

    logic                 ram_we;
    logic [MAP_AW-1:0]    ram_waddr;
    logic [BLOCK_W-1:0]   ram_wdata;
    logic [BLOCK_W-1:0]   ram_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_kind_reg <= 2'd0;
            chip_count_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODEL_KIND: model_kind_reg <= cfg_data[1:0];
                CFG_CHIP_COUNT: chip_count_reg <= cfg_data;
                default:        model_kind_reg <= model_kind_reg;
            endcase
        end
    end

    // segment count and lookup limit
    always_comb
    begin
        case (model_kind_reg)
            MODEL_TWO_SEG:  per_chip = 3'd2;
            MODEL_FOUR_SEG: per_chip = 3'd4;
            default:        per_chip = 3'd0;
        endcase
        chips     = (chip_count_reg > 3'd4) ? 3'd4 : chip_count_reg;
        seg_prod  = {2'b00, per_chip} * {2'b00, chips};
        seg_count = (seg_prod > NSEG_W'(MAX_SEGMENTS)) ? NSEG_W'(MAX_SEGMENTS) : seg_prod;
        lookup_limit = {{(LIMIT_W - NSEG_W){1'b0}}, seg_count} * LIMIT_W'(LOGICAL_PER_SEGMENT);
    end

    // scan record decode
    assign slot      = decode_slot(req_data.addr_copy_a, req_data.addr_copy_b);
    assign good      = req_data.bad_marker == GOOD_MARKER;
    assign scan_flat = {{(FLAT_W - SEG_W){1'b0}}, req_data.segment} * FLAT_W'(PHYS_PER_SEGMENT)
                     + {{(FLAT_W - BLOCK_W){1'b0}}, req_data.phys_block};
    assign scan_addr = {{(FLAT_W - SEG_W){1'b0}}, req_data.segment} * FLAT_W'(LOGICAL_PER_SEGMENT)
                     + {{(FLAT_W - SLOT_W){1'b0}}, slot};
    assign scan_ok   = ({1'b0, req_data.segment} < seg_count)
                     && ({1'b0, req_data.phys_block} < (BLOCK_W + 1)'(PHYS_PER_SEGMENT))
                     && good
                     && (slot < SLOT_W'(LOGICAL_PER_SEGMENT));

    // lookup: range, cache, segment and slot of the logical block
    assign in_range  = {1'b0, req_data.logical_block} < lookup_limit;
    assign cache_hit = cached_valid_reg && (req_data.logical_block == cached_block_reg);

    always_comb
    begin
        lookup_seg = '0;
        for (int k = 1; k < MAX_SEGMENTS; k++)
        begin
            if (req_data.logical_block >= FLAT_W'(k * LOGICAL_PER_SEGMENT))
                lookup_seg = SEG_W'(k);
        end
    end

    assign lookup_off  = req_data.logical_block
                       - {{(FLAT_W - SEG_W){1'b0}}, lookup_seg} * FLAT_W'(LOGICAL_PER_SEGMENT);
    assign lookup_slot = lookup_off[BLOCK_W-1:0];
    assign lookup_miss = (req_data.operation == OP_LOOKUP) && in_range && !cache_hit;

    // verify against the pending lookup
    assign verify_ok      = pending_valid_reg && good && (slot == {1'b0, pending_slot_reg});
    assign pending_sector = sector_of(pending_phys_reg);

    // flat physical block from the map read
    assign map_phys = {{(FLAT_W - SEG_W){1'b0}}, pending_seg_reg} * FLAT_W'(PHYS_PER_SEGMENT)
                    + {{(FLAT_W - BLOCK_W){1'b0}}, ram_rdata};

    // result of an accepted item
    always_comb
    begin
        result.status          = ST_ACCEPTED;
        result.phys_sector     = '0;
        result.decoded_logical = '0;
        case (req_data.operation)
            OP_START_SCAN:
            begin
                result.status = ST_ACCEPTED;
            end
            OP_SCAN_RECORD:
            begin
                result.phys_sector     = sector_of(scan_flat);
                result.decoded_logical = slot;
            end
            OP_LOOKUP:
            begin
                if (!in_range)
                    result.status = ST_NOT_FOUND;
                else if (cache_hit)
                begin
                    result.status      = ST_CACHE_HIT;
                    result.phys_sector = cached_start_reg;
                end
                else
                    result.status = ST_VERIFY_NEEDED;
            end
            OP_VERIFY:
            begin
                result.decoded_logical = slot;
                if (verify_ok)
                begin
                    result.status      = ST_FOUND;
                    result.phys_sector = pending_sector;
                end
                else
                    result.status = ST_NOT_FOUND;
            end
            default:
            begin
                result.status = ST_ACCEPTED;
            end
        endcase
    end

    // cache and pending lookup state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cached_valid_reg    <= 1'b0;
            cached_block_reg    <= '0;
            cached_start_reg    <= '0;
            pending_valid_reg   <= 1'b0;
            pending_logical_reg <= '0;
            pending_slot_reg    <= '0;
            pending_seg_reg     <= '0;
            pending_phys_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                case (req_data.operation)
                    OP_START_SCAN:
                    begin
                        cached_valid_reg  <= 1'b0;
                        cached_block_reg  <= '0;
                        cached_start_reg  <= '0;
                        pending_valid_reg <= 1'b0;
                    end
                    OP_LOOKUP:
                    begin
                        pending_valid_reg <= lookup_miss;
                        if (lookup_miss)
                        begin
                            pending_logical_reg <= req_data.logical_block;
                            pending_slot_reg    <= lookup_slot;
                            pending_seg_reg     <= lookup_seg;
                        end
                    end
                    OP_VERIFY:
                    begin
                        pending_valid_reg <= 1'b0;
                        if (verify_ok)
                        begin
                            cached_valid_reg <= 1'b1;
                            cached_block_reg <= pending_logical_reg;
                            cached_start_reg <= pending_sector;
                        end
                    end
                    default:
                    begin
                        pending_valid_reg <= pending_valid_reg;
                    end
                endcase
            end
            if (cmd.read_done)
            begin
                pending_phys_reg <= map_phys;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rsp_reg <= result;
        end
        else if (cmd.read_done)
        begin
            rsp_reg.status          <= ST_VERIFY_NEEDED;
            rsp_reg.phys_sector     <= sector_of(map_phys);
            rsp_reg.decoded_logical <= '0;
        end
    end

    assign rsp_data = rsp_reg;

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            clear_cnt_reg <= clear_cnt_reg + MAP_AW'(1);
        end
    end

    assign sts.clear_done  = clear_cnt_reg == MAP_AW'(MAP_DEPTH - 1);
    assign sts.lookup_miss = lookup_miss;

    // map write: zeros during the clearing pass, else a good scan record
    assign ram_we    = cmd.clear_en
                     || (cmd.accept && (req_data.operation == OP_SCAN_RECORD) && scan_ok);
    assign ram_waddr = cmd.clear_en ? clear_cnt_reg : scan_addr[MAP_AW-1:0];
    assign ram_wdata = cmd.clear_en ? '0 : req_data.phys_block;

    nlbm_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (req_data.logical_block[MAP_AW-1:0]),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/nand_logical_block_map.sv
// result: registered, valid in the cycle after the item is accepted; a lookup that
//   misses the cache first passes the map read state (registered read of the block map ram)
// flow: one item at a time; a new item is accepted only after the last result is taken
// reset: cache, pending lookup and configuration registers reset at once; the block map
//   then takes a clearing pass over all MAX_SEGMENTS*LOGICAL_PER_SEGMENT entries (16000 by
//   default) during which no item is accepted
`default_nettype none

module nand_logical_block_map #(
    parameter int MAX_SEGMENTS        = nlbm_pkg::MAX_SEGMENTS_DEF,
    parameter int LOGICAL_PER_SEGMENT = nlbm_pkg::LOGICAL_PER_SEGMENT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [nlbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nlbm_pkg::CFG_W-1:0]     cfg_data,
    nlbm_req_if.sink                            req,
    nlbm_rsp_if.source                          rsp
);
    import nlbm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing
    nlbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // map, cache and decode
    nlbm_dp #(
        .MAX_SEGMENTS        (MAX_SEGMENTS),
        .LOGICAL_PER_SEGMENT (LOGICAL_PER_SEGMENT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req.data),
        .rsp_data  (rsp.data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one item in flight: an accepted item closes the input side next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("input accepted while an item is in flight");

    // input and output sides never open together
    a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid)
        else $error("ready while a result is waiting");

    // the map read step only follows a lookup accept
    a_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_done |-> $past(cmd.accept))
        else $error("map read step without an accepted lookup");

    // a not found result carries no sector
    a_not_found_sector: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == ST_NOT_FOUND) |-> rsp.data.phys_sector == '0)
        else $error("not found result with a nonzero sector");

endmodule

`default_nettype wire

>>> sim/tb_nand_logical_block_map.sv
`timescale 1ns / 1ps

module tb_nand_logical_block_map;
    import nlbm_pkg::*;

    localparam int SEGS_MAX    = MAX_SEGMENTS_DEF;
    localparam int LPS         = LOGICAL_PER_SEGMENT_DEF;
    // covers the map clearing pass after reset with a wide margin
    localparam int QUIET_LIMIT = 100000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    nlbm_req_if req_ch ();
    nlbm_rsp_if rsp_ch ();

    nand_logical_block_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // register values as last written
    logic [1:0] model_q;
    logic [2:0] chips_q;

    // translation table state as the block should hold it
    logic [BLOCK_W-1:0]  blk_map [SEGS_MAX*LPS];
    logic                cache_valid;
    logic [FLAT_W-1:0]   cache_lb;
    logic [SECTOR_W-1:0] cache_sector;
    logic                pend_valid;
    logic [FLAT_W-1:0]   pend_lb;
    logic [FLAT_W-1:0]   pend_flat;

    req_t              outgoing_reqs[$];
    rsp_t              due_replies[$];
    logic [FLAT_W-1:0] seen_lbs[$];
    logic [FLAT_W-1:0] last_lb;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int fails          = 0;
    int quiet_cycles   = 0;
    int settings_run   = 0;
    int items_done     = 0;
    int status_seen [5];

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // even-parity tagged address field for a slot
    function automatic logic [15:0] spare_field(input logic [SLOT_W-1:0] slot);
        logic [15:0] f;
        f = {4'h1, slot, 1'b0};
        f[0] = ^f;
        return f;
    endfunction

    // slot carried by the two address copies
    function automatic logic [SLOT_W-1:0] spare_slot(input logic [15:0] a,
                                                    input logic [15:0] b);
        logic tag_a;
        logic tag_b;
        tag_a = a[15:12] == 4'h1;
        tag_b = b[15:12] == 4'h1;
        if (a == b && tag_a)
            return a[11:1];
        if ($countones(a ^ b) > 1)
            return NO_SLOT;
        if (tag_a && ($countones(a) % 2) == 0)
            return a[11:1];
        if (tag_b && ($countones(b) % 2) == 0)
            return b[11:1];
        return NO_SLOT;
    endfunction

    // segments present for the current chip model and chip count
    function automatic int segs_present();
        int per_chip;
        int chips;
        int n;
        per_chip = (model_q == MODEL_TWO_SEG) ? 2 : (model_q == MODEL_FOUR_SEG) ? 4 : 0;
        chips = (chips_q > 3'd4) ? 4 : int'(chips_q);
        n = per_chip * chips;
        return (n > SEGS_MAX) ? SEGS_MAX : n;
    endfunction

    function automatic logic [SECTOR_W-1:0] first_sector(input logic [FLAT_W-1:0] flat);
        logic [SECTOR_W-1:0] s;
        s = SECTOR_W'(flat);
        return SECTOR_W'(s * SECTORS_PER_BLOCK);
    endfunction

    // work out the reply to one accepted item and update the table state
    task automatic map_reply(input req_t it);
        rsp_t               r;
        logic [SLOT_W-1:0]  slot;
        logic               good;
        int                 nseg;
        int                 segi;
        slot = spare_slot(it.addr_copy_a, it.addr_copy_b);
        good = it.bad_marker == GOOD_MARKER;
        nseg = segs_present();
        r.status          = ST_ACCEPTED;
        r.phys_sector     = '0;
        r.decoded_logical = '0;
        case (it.operation)
            OP_START_SCAN:
            begin
                cache_valid  = 1'b0;
                cache_lb     = '0;
                cache_sector = '0;
                pend_valid   = 1'b0;
            end
            OP_SCAN_RECORD:
            begin
                r.phys_sector     = first_sector({it.segment, it.phys_block});
                r.decoded_logical = slot;
                if (int'(it.segment) < nseg && good && int'(slot) < LPS)
                    blk_map[int'(it.segment) * LPS + int'(slot)] = it.phys_block;
            end
            OP_LOOKUP:
            begin
                pend_valid = 1'b0;
                if (int'(it.logical_block) >= LPS * nseg)
                    r.status = ST_NOT_FOUND;
                else if (cache_valid && it.logical_block == cache_lb)
                begin
                    r.status      = ST_CACHE_HIT;
                    r.phys_sector = cache_sector;
                end
                else
                begin
                    segi       = int'(it.logical_block) / LPS;
                    pend_lb    = it.logical_block;
                    pend_flat  = FLAT_W'(segi * PHYS_PER_SEGMENT
                                         + int'(blk_map[it.logical_block]));
                    pend_valid = 1'b1;
                    r.status      = ST_VERIFY_NEEDED;
                    r.phys_sector = first_sector(pend_flat);
                end
            end
            default:
            begin
                // verify of the pending lookup
                r.decoded_logical = slot;
                r.status          = ST_NOT_FOUND;
                if (pend_valid && good && int'(slot) == int'(pend_lb) % LPS)
                begin
                    r.status      = ST_FOUND;
                    r.phys_sector = first_sector(pend_flat);
                    cache_lb      = pend_lb;
                    cache_sector  = r.phys_sector;
                    cache_valid   = 1'b1;
                end
                pend_valid = 1'b0;
            end
        endcase
        status_seen[r.status]++;
        due_replies.push_back(r);
    endtask

    task automatic push_req(input op_t op, input logic [3:0] seg, input logic [9:0] pb,
                            input logic [13:0] lb, input logic [7:0] marker,
                            input logic [15:0] a, input logic [15:0] b);
        req_t it;
        it.operation     = op;
        it.segment       = seg;
        it.phys_block    = pb;
        it.logical_block = lb;
        it.bad_marker    = marker;
        it.addr_copy_a   = a;
        it.addr_copy_b   = b;
        outgoing_reqs.push_back(it);
    endtask

    // address copies for a slot: equal, one bit apart either way, noise, two bits apart
    task automatic spare_pair(input logic [SLOT_W-1:0] slot,
                              output logic [15:0] a, output logic [15:0] b);
        int          v;
        logic [15:0] flip;
        v    = $urandom_range(99);
        flip = 16'(1) << $urandom_range(15);
        a    = spare_field(slot);
        b    = a;
        if (v >= 50 && v < 70)
            b = a ^ flip;
        else if (v >= 70 && v < 90)
            a = a ^ flip;
        else if (v >= 90 && v < 95)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
        end
        else if (v >= 95)
            b = a ^ flip ^ ((flip == 16'h8000) ? 16'h0001 : (flip << 1));
    endtask

    // logical block for a lookup, mostly one that a scan has filled
    function automatic logic [FLAT_W-1:0] pick_lb(input int span);
        int                p;
        logic [FLAT_W-1:0] lb;
        p = $urandom_range(99);
        if (span == 0 || p >= 85)
            return FLAT_W'($urandom);
        if (p < 60 && seen_lbs.size() != 0)
        begin
            lb = seen_lbs[$urandom_range(seen_lbs.size() - 1)];
            if (int'(lb) >= span)
                lb = FLAT_W'(int'(lb) % span);
            return lb;
        end
        return FLAT_W'($urandom_range(span - 1));
    endfunction

    // random traffic, mostly scan records and lookup / verify pairs
    task automatic gen_random(input int n);
        int                cnt;
        int                pick;
        int                v;
        int                nseg;
        int                seg;
        logic [SLOT_W-1:0] slot;
        logic [FLAT_W-1:0] lb;
        logic [7:0]        marker;
        logic [15:0]       a;
        logic [15:0]       b;
        cnt = 0;
        while (cnt < n)
        begin
            nseg = segs_present();
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                seg = (nseg > 0 && $urandom_range(9) != 0) ? $urandom_range(nseg - 1)
                                                           : $urandom_range(15);
                slot = ($urandom_range(9) != 0) ? SLOT_W'($urandom_range(LPS - 1))
                                                : SLOT_W'($urandom_range(2047, LPS));
                marker = ($urandom_range(9) != 0) ? GOOD_MARKER : 8'($urandom);
                spare_pair(slot, a, b);
                push_req(OP_SCAN_RECORD, 4'(seg), 10'($urandom), 14'($urandom), marker, a, b);
                if (seg < nseg && int'(slot) < LPS)
                begin
                    seen_lbs.push_back(FLAT_W'(seg * LPS + int'(slot)));
                    if (seen_lbs.size() > 64)
                        void'(seen_lbs.pop_front());
                end
                cnt++;
            end
            else if (pick < 70)
            begin
                lb = pick_lb(LPS * nseg);
                push_req(OP_LOOKUP, 4'($urandom), 10'($urandom), lb, 8'($urandom),
                         16'($urandom), 16'($urandom));
                v = $urandom_range(99);
                marker = (v >= 75 && v < 85) ? 8'($urandom_range(254)) : GOOD_MARKER;
                slot = (v >= 85) ? SLOT_W'($urandom_range(2047))
                                 : SLOT_W'(int'(lb) % LPS);
                spare_pair(slot, a, b);
                push_req(OP_VERIFY, 4'($urandom), 10'($urandom), 14'($urandom), marker, a, b);
                last_lb = lb;
                cnt += 2;
            end
            else if (pick < 80)
            begin
                // repeat the latest lookup, usually a cache hit
                push_req(OP_LOOKUP, 4'($urandom), 10'($urandom), last_lb, 8'($urandom),
                         16'($urandom), 16'($urandom));
                cnt++;
            end
            else if (pick < 85)
            begin
                push_req(OP_START_SCAN, 4'($urandom), 10'($urandom), 14'($urandom),
                         8'($urandom), 16'($urandom), 16'($urandom));
                cnt++;
            end
            else if (pick < 90)
            begin
                // verify, usually with nothing pending
                spare_pair(SLOT_W'($urandom_range(2047)), a, b);
                push_req(OP_VERIFY, 4'($urandom), 10'($urandom), 14'($urandom),
                         GOOD_MARKER, a, b);
                cnt++;
            end
            else
            begin
                push_req(op_t'($urandom_range(3)), 4'($urandom), 10'($urandom), 14'($urandom),
                         8'($urandom), 16'($urandom), 16'($urandom));
                cnt++;
            end
        end
    endtask

    // wait until every item is in and every reply is out
    task automatic drain();
        while (outgoing_reqs.size() != 0 || req_ch.valid || due_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write both registers while the block is idle, then set the idling mix
    task automatic enter_phase(input logic [2:0] mk, input logic [2:0] cc,
                               input int gap, input int stall);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODEL_KIND;
        cfg_data  <= mk;
        @(posedge clk);
        cfg_index <= CFG_CHIP_COUNT;
        cfg_data  <= cc;
        @(posedge clk);
        cfg_we  <= 1'b0;
        model_q = mk[1:0];
        chips_q = cc;
        send_gap_pct   = gap;
        recv_stall_pct = stall;
        settings_run++;
    endtask

    // item driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (outgoing_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= outgoing_reqs.pop_front();
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: predict accepted items, check replies, watch for a hang
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (req_ch.valid && req_ch.ready)
            begin
                map_reply(req_ch.data);
                items_done++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.data;
                if (due_replies.size() == 0)
                begin
                    $display("%0t: reply with none expected: status %0d sector %0h slot %0d",
                             $time, got.status, got.phys_sector, got.decoded_logical);
                    fails++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        fails++;
                    end
                    if (got.phys_sector !== want.phys_sector)
                    begin
                        $display("%0t: phys_sector expected %0h got %0h",
                                 $time, want.phys_sector, got.phys_sector);
                        fails++;
                    end
                    if (got.decoded_logical !== want.decoded_logical)
                    begin
                        $display("%0t: decoded_logical expected %0d got %0d",
                                 $time, want.decoded_logical, got.decoded_logical);
                        fails++;
                    end
                end
            end
            // watchdog on cycles with no item moving
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d replies outstanding",
                         $time, QUIET_LIMIT, due_replies.size());
                $display("tb_nand_logical_block_map: errors");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        model_q      = 2'd0;
        chips_q      = 3'd1;
        cache_valid  = 1'b0;
        cache_lb     = '0;
        cache_sector = '0;
        pend_valid   = 1'b0;
        pend_lb      = '0;
        pend_flat    = '0;
        last_lb      = '0;
        foreach (blk_map[i])
            blk_map[i] = '0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // full sixteen segment geometry, hand-picked cases first
        enter_phase(3'd2, 3'd4, 0, 0);
        push_req(OP_START_SCAN, 4'd0, 10'd0, 14'd0, 8'h00, 16'h0000, 16'h0000);
        // lowest block, equal copies
        push_req(OP_SCAN_RECORD, 4'd0, 10'd0, 14'd0, GOOD_MARKER,
                 spare_field(11'd0), spare_field(11'd0));
        // top block of the top segment, copy b one bit off
        push_req(OP_SCAN_RECORD, 4'd15, 10'd1023, 14'd0, GOOD_MARKER,
                 spare_field(11'd999), spare_field(11'd999) ^ 16'h0100);
        // copy a one bit off with odd parity, copy b taken
        push_req(OP_SCAN_RECORD, 4'd3, 10'd517, 14'd0, GOOD_MARKER,
                 spare_field(11'd500) ^ 16'h0004, spare_field(11'd500));
        // bad block leaves the map alone
        push_req(OP_SCAN_RECORD, 4'd1, 10'd44, 14'd0, 8'h00,
                 spare_field(11'd10), spare_field(11'd10));
        // slot past the end of the segment
        push_req(OP_SCAN_RECORD, 4'd2, 10'd9, 14'd0, GOOD_MARKER,
                 spare_field(11'd1000), spare_field(11'd1000));
        // copies two bits apart
        push_req(OP_SCAN_RECORD, 4'd2, 10'd10, 14'd0, GOOD_MARKER,
                 spare_field(11'd5), spare_field(11'd5) ^ 16'h0006);
        // equal copies without the tag nibble
        push_req(OP_SCAN_RECORD, 4'd2, 10'd11, 14'd0, GOOD_MARKER, 16'h2010, 16'h2010);
        // equal tagged copies with odd parity still decode
        push_req(OP_SCAN_RECORD, 4'd4, 10'd300, 14'd0, GOOD_MARKER,
                 spare_field(11'd77) ^ 16'h0001, spare_field(11'd77) ^ 16'h0001);
        // miss, confirm, then cache hit
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'd0, 8'h00, 16'h0000, 16'h0000);
        push_req(OP_VERIFY, 4'd0, 10'd0, 14'd0, GOOD_MARKER,
                 spare_field(11'd0), spare_field(11'd0));
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'd0, 8'h00, 16'h0000, 16'h0000);
        // last logical block, verify sees a bad block
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'd15999, 8'h00, 16'h0000, 16'h0000);
        push_req(OP_VERIFY, 4'd0, 10'd0, 14'd0, 8'h7f,
                 spare_field(11'd999), spare_field(11'd999));
        // verify with nothing pending
        push_req(OP_VERIFY, 4'd0, 10'd0, 14'd0, GOOD_MARKER,
                 spare_field(11'd999), spare_field(11'd999));
        // lookups past the last segment
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'd16000, 8'h00, 16'h0000, 16'h0000);
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'h3fff, 8'h00, 16'h0000, 16'h0000);
        // verify names the wrong slot
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'd3500, 8'h00, 16'h0000, 16'h0000);
        push_req(OP_VERIFY, 4'd0, 10'd0, 14'd0, GOOD_MARKER,
                 spare_field(11'd501), spare_field(11'd501));
        // a second lookup drops the first pending one
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'd4077, 8'h00, 16'h0000, 16'h0000);
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'd3500, 8'h00, 16'h0000, 16'h0000);
        push_req(OP_VERIFY, 4'd0, 10'd0, 14'd0, GOOD_MARKER,
                 spare_field(11'd77), spare_field(11'd77));
        // start scan empties the cache
        push_req(OP_START_SCAN, 4'd0, 10'd0, 14'd0, 8'h00, 16'h0000, 16'h0000);
        push_req(OP_LOOKUP, 4'd0, 10'd0, 14'd0, 8'h00, 16'h0000, 16'h0000);
        // every field but the operation at its top value
        push_req(OP_SCAN_RECORD, 4'hf, 10'h3ff, 14'h3fff, 8'hff, 16'hffff, 16'hffff);
        gen_random(130);

        // two segments, sender idling
        enter_phase(3'd1, 3'd1, 55, 0);
        gen_random(130);
        // chip count past four saturates, receiver stalling
        enter_phase(3'd2, 3'd7, 0, 55);
        gen_random(130);
        // no chip model: no segments at all
        enter_phase(3'd0, 3'd2, 23, 23);
        gen_random(60);
        // model code three with the upper data bit set, zero chips
        enter_phase(3'd7, 3'd0, 23, 23);
        gen_random(60);
        // eight segments, no idling
        enter_phase(3'd1, 3'd4, 0, 0);
        gen_random(130);
        // twelve segments, both sides idling
        enter_phase(3'd2, 3'd3, 23, 23);
        gen_random(130);
        // back to sixteen segments with sender gaps
        enter_phase(3'd2, 3'd4, 55, 0);
        gen_random(100);

        drain();
        repeat (10) @(posedge clk);
        $display("ran %0d items under %0d register settings with %0d mismatches",
                 items_done, settings_run, fails);
        $display("replies: %0d accepted, %0d cache hits, %0d verify requests,",
                 status_seen[0], status_seen[1], status_seen[2]);
        $display("         %0d found, %0d not found",
                 status_seen[3], status_seen[4]);
        if (fails == 0 && due_replies.size() == 0)
            $display("tb_nand_logical_block_map: clean");
        else
            $display("tb_nand_logical_block_map: errors");
        $finish;
    end

endmodule
